>>> rtl/core/assert_macros.svh
// Assertion helper macros for the display driver RTL.
// Every macro samples on aclk and is disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every sampled edge
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// ante in a cycle implies cons in the same cycle
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// ante in a cycle implies cons in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/tmd_pkg.sv
// Shared types, constants and pin pattern decoders for the two-tube driver.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tmd_pkg;

    localparam logic       OP_TICK     = 1'b0;
    localparam logic       OP_SET      = 1'b1;

    localparam logic [3:0] BLANK_CODE  = 4'd15;
    localparam logic [3:0] SYMBOL_CODE = 4'd10;
    localparam logic [8:0] BLANK_PINS  = 9'h092;

    localparam int         LEVEL_STEP  = 5;
    localparam logic [4:0] MAX_STEP    = 5'd20;
    localparam logic [7:0] MAX_PERCENT = 8'd100;

    typedef struct packed {
        logic [3:0] tens_code;
        logic [3:0] units_code;
        logic [4:0] target_step;
    } set_cmd_t;

    typedef struct packed {
        logic [8:0] pin_levels;
        logic       lit_tube;
        logic [6:0] level;
    } result_t;

    function automatic logic [8:0] tens_pattern(input logic [3:0] code);
        logic [8:0] pins;
        unique case (code)
            4'd0:    pins = 9'h090;
            4'd1:    pins = 9'h091;
            4'd2:    pins = 9'h095;
            4'd3:    pins = 9'h094;
            4'd4:    pins = 9'h096;
            4'd5:    pins = 9'h097;
            4'd6:    pins = 9'h093;
            4'd7:    pins = 9'h0B2;
            4'd8:    pins = 9'h0BA;
            4'd9:    pins = 9'h09A;
            default: pins = BLANK_PINS;
        endcase
        return pins;
    endfunction

    function automatic logic [8:0] units_pattern(input logic [3:0] code);
        logic [8:0] pins;
        unique case (code)
            4'd0:        pins = 9'h1D2;
            4'd1:        pins = 9'h0D2;
            4'd2:        pins = 9'h082;
            4'd3:        pins = 9'h08A;
            4'd4:        pins = 9'h0AA;
            4'd5:        pins = 9'h012;
            4'd6:        pins = 9'h052;
            4'd7:        pins = 9'h152;
            4'd8:        pins = 9'h112;
            4'd9:        pins = 9'h192;
            SYMBOL_CODE: pins = 9'h0A2;
            default:     pins = BLANK_PINS;
        endcase
        return pins;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/tmd_set_decode.sv
// Set-display decode: splits the value into tube digit codes and quantizes brightness.
// Depends on tmd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tmd_set_decode (
    input  wire logic [7:0]        shown_value,
    input  wire logic [7:0]        brightness,
    input  wire logic              cycling,
    output tmd_pkg::set_cmd_t      set_cmd
);

    logic [15:0] tens_prod;
    logic [4:0]  tens_raw;
    logic [7:0]  tens_x10;
    logic [3:0]  units_raw;
    logic [7:0]  bright_clamped;
    logic [15:0] step_prod;

    // value / 10 via reciprocal 205/2048, exact for 8-bit values
    assign tens_prod = 16'(shown_value) * 16'd205;
    assign tens_raw  = tens_prod[15:11];
    assign tens_x10  = {tens_raw[4:0], 3'b000} + {2'b00, tens_raw, 1'b0};
    assign units_raw = 4'(shown_value - tens_x10);

    // brightness / 5 via 205/1024, exact up to 100
    assign bright_clamped = (brightness > tmd_pkg::MAX_PERCENT) ? tmd_pkg::MAX_PERCENT
                                                                 : brightness;
    assign step_prod      = 16'(bright_clamped) * 16'd205;

    always_comb begin
        set_cmd.target_step = step_prod[14:10];
        set_cmd.units_code  = units_raw;
        set_cmd.tens_code   = (tens_raw > 5'd9) ? tmd_pkg::BLANK_CODE : tens_raw[3:0];
        if (cycling) begin
            if (shown_value == 8'd10) begin
                set_cmd.tens_code  = tmd_pkg::BLANK_CODE;
                set_cmd.units_code = tmd_pkg::SYMBOL_CODE;
            end
        end else if (tens_raw == 5'd0) begin
            set_cmd.tens_code = tmd_pkg::BLANK_CODE;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/tmd_mux_core.sv
// Display state: fade ramp, two-phase multiplex timer and pin register.
// Depends on tmd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module tmd_mux_core #(
    parameter int MUX_FREQUENCY = 25
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [7:0]        cfg_wr_data,
    input  wire logic              upd_en,
    input  wire logic              operation,
    input  wire tmd_pkg::set_cmd_t set_cmd,
    output tmd_pkg::result_t       rslt_next
);

    localparam int PHASE_TICKS = 500 / MUX_FREQUENCY;
    localparam int ON_W        = $clog2(PHASE_TICKS + 1);

    logic [ON_W-1:0] on_lut [32];

    for (genvar i = 0; i < 32; i++) begin : g_on_lut
        localparam int ON_TICKS = (i <= 20)
                                ? (tmd_pkg::LEVEL_STEP * tmd_pkg::LEVEL_STEP * i) / MUX_FREQUENCY
                                : 0;
        assign on_lut[i] = ON_W'(ON_TICKS);
    end

    logic [7:0]      ramp_interval_reg;
    logic [4:0]      cur_step_reg,   cur_step_next;
    logic [4:0]      target_step_reg, target_step_next;
    logic [ON_W-1:0] on_dur_reg,     on_dur_next;
    logic [7:0]      ramp_el_reg,    ramp_el_next;
    logic [7:0]      phase_el_reg,   phase_el_next;
    logic            phase_reg,      phase_next;
    logic [3:0]      tens_reg,       tens_next;
    logic [3:0]      units_reg,      units_next;
    logic [8:0]      pin_reg,        pin_next;

    logic [7:0]      ramp_inc;
    logic [7:0]      phase_inc;
    logic            ramp_fire;

    assign ramp_inc  = (ramp_el_reg  == 8'hFF) ? ramp_el_reg  : ramp_el_reg  + 8'd1;
    assign phase_inc = (phase_el_reg == 8'hFF) ? phase_el_reg : phase_el_reg + 8'd1;
    assign ramp_fire = (ramp_inc >= ramp_interval_reg);

    always_comb begin
        cur_step_next    = cur_step_reg;
        target_step_next = target_step_reg;
        on_dur_next      = on_dur_reg;
        ramp_el_next     = ramp_el_reg;
        phase_el_next    = phase_el_reg;
        phase_next       = phase_reg;
        tens_next        = tens_reg;
        units_next       = units_reg;
        pin_next         = pin_reg;

        if (operation == tmd_pkg::OP_SET) begin
            target_step_next = set_cmd.target_step;
            tens_next        = set_cmd.tens_code;
            units_next       = set_cmd.units_code;
        end else begin
            ramp_el_next  = ramp_inc;
            phase_el_next = phase_inc;
            if (ramp_fire) begin
                if (target_step_reg > cur_step_reg) begin
                    cur_step_next = cur_step_reg + 5'd1;
                end else if (target_step_reg < cur_step_reg) begin
                    cur_step_next = cur_step_reg - 5'd1;
                end
                on_dur_next  = on_lut[cur_step_next];
                ramp_el_next = 8'd0;
            end
            if (phase_inc >= 8'(on_dur_next)) begin
                if (phase_inc >= 8'(PHASE_TICKS)) begin
                    if (on_dur_next != '0) begin
                        pin_next = phase_reg ? tmd_pkg::tens_pattern(tens_reg)
                                             : tmd_pkg::units_pattern(units_reg);
                    end
                    phase_next    = ~phase_reg;
                    phase_el_next = 8'd0;
                end else begin
                    pin_next = tmd_pkg::BLANK_PINS;
                end
            end
        end
    end

    always_comb begin
        rslt_next.pin_levels = pin_next;
        rslt_next.lit_tube   = phase_next;
        rslt_next.level      = {cur_step_next, 2'b00} + {2'b00, cur_step_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ramp_interval_reg <= 8'd140;
            cur_step_reg      <= '0;
            target_step_reg   <= '0;
            on_dur_reg        <= '0;
            ramp_el_reg       <= '0;
            phase_el_reg      <= '0;
            phase_reg         <= 1'b0;
            tens_reg          <= tmd_pkg::BLANK_CODE;
            units_reg         <= tmd_pkg::BLANK_CODE;
            pin_reg           <= '0;
        end else begin
            if (cfg_wr_en) begin
                ramp_interval_reg <= cfg_wr_data;
            end
            if (upd_en) begin
                cur_step_reg    <= cur_step_next;
                target_step_reg <= target_step_next;
                on_dur_reg      <= on_dur_next;
                ramp_el_reg     <= ramp_el_next;
                phase_el_reg    <= phase_el_next;
                phase_reg       <= phase_next;
                tens_reg        <= tens_next;
                units_reg       <= units_next;
                pin_reg         <= pin_next;
            end
        end
    end

    `ASSERT_ALWAYS(a_step_range, cur_step_reg <= tmd_pkg::MAX_STEP, "fade level out of range")
    `ASSERT_ALWAYS(a_phase_el_range, phase_el_reg <= 8'(PHASE_TICKS), "phase timer overran")
    `ASSERT_IMPLIES(a_phase_flip, $past(aresetn) && (phase_reg != $past(phase_reg)),
                    phase_el_reg == 8'd0, "phase flipped without timer restart")
    `ASSERT_NEXT(a_pins_hold, !upd_en || (operation == tmd_pkg::OP_SET),
                 $stable(pin_reg) && $stable(phase_reg), "display moved without tick")

endmodule

`default_nettype wire

>>> rtl/core/two_tube_mux_fade_driver.sv
// Top level of the two-tube multiplexed display driver with brightness fade.
// Depends on tmd_pkg, tmd_set_decode and tmd_mux_core.
//
//   channel  direction  handshake          beat contents
//   s_       in         s_valid/s_ready    operation, shown_value, brightness, cycling
//   m_       out        m_valid/m_ready    pin_levels, lit_tube, level
//   cfg_     in         cfg_wr_en          ramp_interval (8 bit)
//
// One beat per cycle sustained while m_ready stays high; an accepted beat goes to the input
// register, then its result goes to the result register, which drives m_valid.
// The input register and the result register decouple the sides, so a new beat
// is taken while a result waits; the whole state update is one pass in between.
// Synchronous active-low reset; no clearing pass, the block is ready right after.
`timescale 1ns / 1ps
`default_nettype none

module two_tube_mux_fade_driver #(
    parameter int MUX_FREQUENCY = 25
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_operation,
    input  wire logic [7:0] s_shown_value,
    input  wire logic [7:0] s_brightness,
    input  wire logic       s_cycling,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [8:0]      m_pin_levels,
    output logic            m_lit_tube,
    output logic [6:0]      m_level
);

    logic              in_valid_reg;
    logic              in_op_reg;
    logic [7:0]        in_value_reg;
    logic [7:0]        in_bright_reg;
    logic              in_cycling_reg;
    logic              out_valid_reg;
    tmd_pkg::result_t  out_reg;
    tmd_pkg::result_t  rslt_next;
    tmd_pkg::set_cmd_t set_cmd;
    logic              advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    tmd_set_decode u_set_decode (
        .shown_value (in_value_reg),
        .brightness  (in_bright_reg),
        .cycling     (in_cycling_reg),
        .set_cmd     (set_cmd)
    );

    tmd_mux_core #(
        .MUX_FREQUENCY (MUX_FREQUENCY)
    ) u_mux_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .upd_en      (advance),
        .operation   (in_op_reg),
        .set_cmd     (set_cmd),
        .rslt_next   (rslt_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_op_reg      <= s_operation;
            in_value_reg   <= s_shown_value;
            in_bright_reg  <= s_brightness;
            in_cycling_reg <= s_cycling;
        end
        if (advance) begin
            out_reg <= rslt_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_pin_levels = out_reg.pin_levels;
    assign m_lit_tube   = out_reg.lit_tube;
    assign m_level      = out_reg.level;

endmodule

`default_nettype wire

>>> test/two_tube_mux_fade_driver_test.sv
// Self-checking bench for two_tube_mux_fade_driver: digit split, brightness fade and multiplex.
// A scoreboard class predicts every result beat in order; depends on tmd_pkg and the DUT.
`timescale 1ns / 1ps

module two_tube_mux_fade_driver_test;

    localparam int MUX_FREQ     = 25;
    localparam int PHASE_TICKS  = 500 / MUX_FREQ;
    localparam int RANDOM_ITEMS = 1400;
    localparam int PHASES       = 7;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;

    // digit glyphs, code 0 in the low slice
    localparam logic [10*9-1:0] TENS_GLYPHS = {
        9'h09A, 9'h0BA, 9'h0B2, 9'h093, 9'h097,
        9'h096, 9'h094, 9'h095, 9'h091, 9'h090
    };
    localparam logic [11*9-1:0] UNITS_GLYPHS = {
        9'h0A2, 9'h192, 9'h112, 9'h152, 9'h052, 9'h012,
        9'h0AA, 9'h08A, 9'h082, 9'h0D2, 9'h1D2
    };
    localparam logic [PHASES*8-1:0] RAMP_PLAN = {
        8'd1, 8'd140, 8'd2, 8'd0, 8'd3, 8'd255, 8'd1
    };

    class tube_display_board;
        logic [7:0] ramp_interval = 8'd140;
        logic [6:0] cur_level     = '0;
        logic [6:0] tgt_level     = '0;
        logic [4:0] on_time       = '0;
        logic [7:0] ramp_count    = '0;
        logic [7:0] phase_count   = '0;
        logic       lit           = 1'b0;
        logic [3:0] tens          = tmd_pkg::BLANK_CODE;
        logic [3:0] units         = tmd_pkg::BLANK_CODE;
        logic [8:0] pins          = '0;
        tmd_pkg::result_t expected_frames[$];
        int         mismatches    = 0;
        int         checked       = 0;

        function void note_beat(logic op, logic [7:0] value, logic [7:0] bright, logic cyc);
            int      tens_v;
            int      units_v;
            int      b;
            tmd_pkg::result_t frame;
            if (op == tmd_pkg::OP_SET) begin
                tens_v  = value / 10;
                units_v = value % 10;
                b = (bright > tmd_pkg::MAX_PERCENT) ? int'(tmd_pkg::MAX_PERCENT)
                                                     : int'(bright);
                tgt_level = 7'((b / tmd_pkg::LEVEL_STEP) * tmd_pkg::LEVEL_STEP);
                if (tens_v > 9)
                    tens_v = tmd_pkg::BLANK_CODE;
                if (cyc) begin
                    if (value == 8'd10) begin
                        tens_v  = tmd_pkg::BLANK_CODE;
                        units_v = tmd_pkg::SYMBOL_CODE;
                    end
                end else if (tens_v == 0) begin
                    tens_v = tmd_pkg::BLANK_CODE;
                end
                tens  = 4'(tens_v);
                units = 4'(units_v);
            end else begin
                if (ramp_count != 8'hFF)
                    ramp_count++;
                if (phase_count != 8'hFF)
                    phase_count++;
                if (ramp_count >= ramp_interval) begin
                    if (tgt_level > cur_level)
                        cur_level = cur_level + 7'(tmd_pkg::LEVEL_STEP);
                    else if (tgt_level < cur_level)
                        cur_level = cur_level - 7'(tmd_pkg::LEVEL_STEP);
                    on_time    = 5'((tmd_pkg::LEVEL_STEP * int'(cur_level)) / MUX_FREQ);
                    ramp_count = '0;
                end
                if (phase_count >= on_time) begin
                    if (phase_count >= PHASE_TICKS) begin
                        if (on_time != 0) begin
                            if (lit == 1'b0)
                                pins = (units < 11) ? UNITS_GLYPHS[int'(units)*9 +: 9]
                                                    : tmd_pkg::BLANK_PINS;
                            else
                                pins = (tens < 10) ? TENS_GLYPHS[int'(tens)*9 +: 9]
                                                   : tmd_pkg::BLANK_PINS;
                        end
                        lit         = ~lit;
                        phase_count = '0;
                    end else begin
                        pins = tmd_pkg::BLANK_PINS;
                    end
                end
            end
            frame.pin_levels = pins;
            frame.lit_tube   = lit;
            frame.level      = cur_level;
            expected_frames.push_back(frame);
        endfunction

        function void check_beat(logic [8:0] got_pins, logic got_tube, logic [6:0] got_level);
            tmd_pkg::result_t want;
            checked++;
            if (expected_frames.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: pins %h tube %0d level %0d",
                             got_pins, got_tube, got_level);
                return;
            end
            want = expected_frames.pop_front();
            if (got_pins !== want.pin_levels || got_tube !== want.lit_tube ||
                got_level !== want.level) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("beat %0d: pins %h/%h tube %0d/%0d level %0d/%0d (exp/got)",
                             checked, want.pin_levels, got_pins, want.lit_tube, got_tube,
                             want.level, got_level);
            end
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction
    endclass

    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       cfg_wr_en     = 1'b0;
    logic [7:0] cfg_wr_data   = '0;
    logic       s_valid       = 1'b0;
    logic       s_ready;
    logic       s_operation   = tmd_pkg::OP_TICK;
    logic [7:0] s_shown_value = '0;
    logic [7:0] s_brightness  = '0;
    logic       s_cycling     = 1'b0;
    logic       m_valid;
    logic       m_ready       = 1'b0;
    logic [8:0] m_pin_levels;
    logic       m_lit_tube;
    logic [6:0] m_level;

    tube_display_board board = new;
    int  cycle_count = 0;
    int  tick_count  = 0;
    int  set_count   = 0;
    bit  steady      = 1'b0;

    two_tube_mux_fade_driver #(
        .MUX_FREQUENCY(MUX_FREQ)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_shown_value(s_shown_value),
        .s_brightness (s_brightness),
        .s_cycling    (s_cycling),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pin_levels (m_pin_levels),
        .m_lit_tube   (m_lit_tube),
        .m_level      (m_level)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 35);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
                     board.pending());
            $display("FAILED: results differ");
            $finish;
        end
        if (aresetn && m_valid && m_ready)
            board.check_beat(m_pin_levels, m_lit_tube, m_level);
    end

    task automatic send_beat(input logic op, input logic [7:0] value,
                             input logic [7:0] bright, input logic cyc);
        if (!steady && $urandom_range(99) < 35) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 35);
        end
        s_valid       <= 1'b1;
        s_operation   <= op;
        s_shown_value <= value;
        s_brightness  <= bright;
        s_cycling     <= cyc;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_beat(op, value, bright, cyc);
        if (op == tmd_pkg::OP_SET)
            set_count++;
        else
            tick_count++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_ramp(input logic [7:0] interval);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= interval;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        board.ramp_interval = interval;
    endtask

    // mostly ticks so the fade and multiplex run; sets carry random content
    task automatic random_beat();
        logic [7:0] value;
        logic [7:0] bright;
        value  = 8'($urandom_range(255));
        bright = 8'($urandom_range(255));
        if ($urandom_range(99) < 14) begin
            case ($urandom_range(3))
                0: value = 8'($urandom_range(20));
                1: value = 8'($urandom_range(105, 95));
                default: ;
            endcase
            case ($urandom_range(3))
                0: bright = 8'($urandom_range(100));
                1: bright = 8'(5 * $urandom_range(20));
                default: ;
            endcase
            send_beat(tmd_pkg::OP_SET, value, bright, 1'($urandom_range(1)));
        end else begin
            send_beat(tmd_pkg::OP_TICK, value, bright, 1'($urandom_range(1)));
        end
    endtask

    initial begin
        int phase_idx;
        int item_idx;
        aresetn = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset state, zero on time, digit split corners
        send_beat(tmd_pkg::OP_TICK, 8'd0, 8'd0, 1'b0);
        send_beat(tmd_pkg::OP_TICK, 8'hFF, 8'hFF, 1'b1);
        send_beat(tmd_pkg::OP_SET, 8'd0, 8'd0, 1'b0);
        send_beat(tmd_pkg::OP_SET, 8'd255, 8'd255, 1'b1);
        send_beat(tmd_pkg::OP_SET, 8'd10, 8'd100, 1'b0);
        send_beat(tmd_pkg::OP_SET, 8'd9, 8'd97, 1'b1);
        send_beat(tmd_pkg::OP_SET, 8'd100, 8'd101, 1'b0);
        send_beat(tmd_pkg::OP_SET, 8'd42, 8'd4, 1'b1);
        // every-tick fade toward full: on time rises but stays below the half period
        write_ramp(8'd0);
        send_beat(tmd_pkg::OP_SET, 8'd10, 8'd100, 1'b1);
        repeat (17) send_beat(tmd_pkg::OP_TICK, 8'd0, 8'd0, 1'b0);

        for (phase_idx = 0; phase_idx < PHASES; phase_idx++) begin
            write_ramp(RAMP_PLAN[phase_idx*8 +: 8]);
            steady = (phase_idx == 4);
            for (item_idx = 0; item_idx < RANDOM_ITEMS / PHASES; item_idx++) begin
                if (phase_idx == 2 && item_idx == 100)
                    drain_results();
                random_beat();
            end
        end
        steady = 1'b0;
        drain_results();

        $display("covered %0d tick and %0d set beats over %0d ramp settings, incl. 0 and 255;",
                 tick_count, set_count, PHASES + 2);
        $display("%0d result beats checked, %0d mismatches", board.checked, board.mismatches);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/tmd_pkg.sv
rtl/core/tmd_set_decode.sv
rtl/core/tmd_mux_core.sv
rtl/core/two_tube_mux_fade_driver.sv
test/two_tube_mux_fade_driver_test.sv
